>>> src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and timing helpers of the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int US_W   = 10;
    localparam int BIT_W  = 3;
    localparam int BYTE_W = 8;

    localparam logic [US_W-1:0] RESET_LOW_DEF  = 10'd480;
    localparam logic [US_W-1:0] PRES_WAIT_DEF  = 10'd60;
    localparam logic [US_W-1:0] PRES_TAIL_DEF  = 10'd240;
    localparam logic [US_W-1:0] READ_SAMP_DEF  = 10'd14;
    localparam logic [US_W-1:0] READ_TAIL_DEF  = 10'd46;
    localparam logic [US_W-1:0] W1_LOW_DEF     = 10'd2;
    localparam logic [US_W-1:0] W_SLOT_DEF     = 10'd60;
    localparam logic [US_W-1:0] RECOVERY_DEF   = 10'd2;

    localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RLOW,
        PH_RWAIT,
        PH_RSAMP,
        PH_RTAIL,
        PH_W1LOW,
        PH_W1HIGH,
        PH_W0LOW,
        PH_RECOV,
        PH_RDLOW,
        PH_RDWAIT,
        PH_RDSAMP,
        PH_RDTAIL
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_RESET,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    typedef enum logic [1:0] {
        DRV_RELEASE,
        DRV_LOW,
        DRV_HIGH
    } t_drive;

    typedef enum logic [2:0] {
        REG_RESET_LOW,
        REG_PRES_WAIT,
        REG_PRES_TAIL,
        REG_READ_SAMP,
        REG_READ_TAIL,
        REG_W1_LOW,
        REG_W_SLOT,
        REG_RECOVERY
    } t_reg_idx;

    typedef struct packed {
        logic [US_W-1:0] reset_low;
        logic [US_W-1:0] pres_wait;
        logic [US_W-1:0] pres_tail;
        logic [US_W-1:0] read_samp;
        logic [US_W-1:0] read_tail;
        logic [US_W-1:0] w1_low;
        logic [US_W-1:0] w_slot;
        logic [US_W-1:0] recovery;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [BIT_W-1:0]    bit_idx;
        logic [BYTE_W-1:0]   shift;
        logic [BYTE_W-1:0]   rd_val;
    } t_seq;

    typedef struct packed {
        t_drive              drive;
        logic                busy;
        logic                done;
        logic                presence;
        logic [BYTE_W-1:0]   read_value;
        logic                rejected;
    } t_res;

    function automatic logic [US_W-1:0] phase_ticks(t_phase p, t_cfg c);
        logic [US_W-1:0] lo;
        logic [US_W-1:0] slot;
        logic [US_W-1:0] r;
        lo   = (c.w1_low == '0) ? 10'd1 : c.w1_low;
        slot = (c.w_slot < 10'd2) ? 10'd2 : c.w_slot;
        case (p)
            PH_RLOW:   r = (c.reset_low == '0) ? 10'd1 : c.reset_low;
            PH_RWAIT:  r = (c.pres_wait == '0) ? 10'd1 : c.pres_wait;
            PH_RSAMP:  r = 10'd1;
            PH_RTAIL:  r = c.pres_tail;
            PH_W1LOW:  r = lo;
            PH_W1HIGH: r = (slot > lo) ? slot - lo : '0;
            PH_W0LOW:  r = slot;
            PH_RECOV:  r = c.recovery;
            PH_RDLOW:  r = 10'd1;
            PH_RDWAIT: r = (c.read_samp == '0) ? 10'd1 : c.read_samp;
            PH_RDSAMP: r = 10'd1;
            PH_RDTAIL: r = c.read_tail;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic t_drive phase_drive(t_phase p);
        t_drive d;
        case (p)
            PH_RLOW, PH_W1LOW, PH_W0LOW, PH_RDLOW: d = DRV_LOW;
            PH_W1HIGH:                             d = DRV_HIGH;
            default:                               d = DRV_RELEASE;
        endcase
        return d;
    endfunction

    // next phase, with the end-of-bit bookkeeping
    function automatic t_seq successor(t_seq s);
        t_seq n;
        n = s;
        case (s.phase)
            PH_RLOW:   n.phase = PH_RWAIT;
            PH_RWAIT:  n.phase = PH_RSAMP;
            PH_RSAMP:  n.phase = PH_RTAIL;
            PH_W1LOW:  n.phase = PH_W1HIGH;
            PH_W1HIGH: n.phase = PH_RECOV;
            PH_W0LOW:  n.phase = PH_RECOV;
            PH_RECOV: begin
                if (s.bit_idx == LAST_BIT) begin
                    n.phase = PH_IDLE;
                end else begin
                    n.bit_idx = s.bit_idx + 3'd1;
                    n.shift   = {1'b0, s.shift[BYTE_W-1:1]};
                    n.phase   = s.shift[1] ? PH_W1LOW : PH_W0LOW;
                end
            end
            PH_RDLOW:  n.phase = PH_RDWAIT;
            PH_RDWAIT: n.phase = PH_RDSAMP;
            PH_RDSAMP: n.phase = PH_RDTAIL;
            PH_RDTAIL: begin
                if (s.bit_idx == LAST_BIT) begin
                    n.rd_val = s.shift;
                    n.phase  = PH_IDLE;
                end else begin
                    n.bit_idx = s.bit_idx + 3'd1;
                    n.phase   = PH_RDLOW;
                end
            end
            default:   n.phase = PH_IDLE;
        endcase
        return n;
    endfunction

endpackage

>>> src/one_wire_bus_master_unit.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit
// Timed 1-Wire bus master, one request per microsecond tick.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one microsecond of bus time: an optional
// command (reset with presence detect, write byte, read byte), the byte to
// write and the bus level sampled on that tick. Every request yields exactly
// one result on the master stream with the line drive for that tick, busy,
// done, presence, the last read byte and a rejected flag for a command that
// arrived while an operation was running.
// A result is registered and appears on the cycle after its request is
// accepted. Throughput is one request per cycle while the receiver takes results; the sequencer finishes a
// tick's phase, timer and shifter update in the cycle the request is taken,
// and the result sits in an output register meanwhile.
// When the receiver stalls, the output register holds its result and the
// slave side takes a new request only in a cycle where that register empties.
// Reset clears the sequencer to idle, flags and read byte to zero, and loads
// the timing registers with their default values (480, 60, 240, 14, 46, 2,
// 60, 2 us). Timing registers are written through i_cfg_we; the user writes them only while idle, unenforced.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit import owbm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [15:0]        i_s_tdata,   // command[1:0], data_byte[9:2], line_sample[10]
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [15:0]        o_m_tdata,   // line_drive[1:0], busy_res[2], done_res[3],
                                            // presence_found[4], read_value[12:5],
                                            // rejected[13]
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [US_W-1:0]    i_cfg_data
);

    t_cfg   r_cfg;
    logic   r_out_valid;
    t_res   r_out;
    t_res   core_res;
    logic   step;

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign step       = i_s_tvalid & o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low <= RESET_LOW_DEF;
            r_cfg.pres_wait <= PRES_WAIT_DEF;
            r_cfg.pres_tail <= PRES_TAIL_DEF;
            r_cfg.read_samp <= READ_SAMP_DEF;
            r_cfg.read_tail <= READ_TAIL_DEF;
            r_cfg.w1_low    <= W1_LOW_DEF;
            r_cfg.w_slot    <= W_SLOT_DEF;
            r_cfg.recovery  <= RECOVERY_DEF;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RESET_LOW: r_cfg.reset_low <= i_cfg_data;
                REG_PRES_WAIT: r_cfg.pres_wait <= i_cfg_data;
                REG_PRES_TAIL: r_cfg.pres_tail <= i_cfg_data;
                REG_READ_SAMP: r_cfg.read_samp <= i_cfg_data;
                REG_READ_TAIL: r_cfg.read_tail <= i_cfg_data;
                REG_W1_LOW:    r_cfg.w1_low    <= i_cfg_data;
                REG_W_SLOT:    r_cfg.w_slot    <= i_cfg_data;
                REG_RECOVERY:  r_cfg.recovery  <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    owbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cmd   (t_cmd'(i_s_tdata[1:0])),
        .i_data  (i_s_tdata[9:2]),
        .i_line  (i_s_tdata[10]),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out.rejected, r_out.read_value, r_out.presence,
                         r_out.done, r_out.busy, r_out.drive};

    a_done_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done |-> r_out.busy)
        else $error("done reported outside an operation");

    a_reject_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> r_out.busy)
        else $error("reject reported while idle");

    a_idle_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.busy |-> r_out.drive == DRV_RELEASE)
        else $error("line driven while idle");

endmodule

>>> src/owbm_core.sv
// ----------------------------------------------------------------------------
// owbm_core
// Bus timing sequencer: advances phase, timer and bit shifter once per tick.
// ----------------------------------------------------------------------------
module owbm_core import owbm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_cmd               i_cmd,
    input  logic [BYTE_W-1:0]  i_data,
    input  logic               i_line,
    input  t_cfg               i_cfg,
    output t_res               o_res
);

    t_phase             r_phase;
    logic [US_W-1:0]    r_time_left;
    logic [BIT_W-1:0]   r_bit_idx;
    logic [BYTE_W-1:0]  r_shift;
    logic               r_presence;
    logic [BYTE_W-1:0]  r_read;

    t_seq               s0, s1, s2, s3;
    logic [US_W-1:0]    t0, tdec;
    logic               busy, rej, done, pres;
    t_seq               n_seq;
    logic [US_W-1:0]    n_time_left;

    always_comb begin
        s0.phase   = r_phase;
        s0.bit_idx = r_bit_idx;
        s0.shift   = r_shift;
        s0.rd_val  = r_read;
        t0         = r_time_left;
        rej        = 1'b0;
        pres       = r_presence;
        if (r_phase != PH_IDLE) begin
            rej = (i_cmd != CMD_NONE);
        end else if (i_cmd != CMD_NONE) begin
            s0.bit_idx = '0;
            case (i_cmd)
                CMD_RESET: begin
                    s0.shift = '0;
                    s0.phase = PH_RLOW;
                end
                CMD_WRITE: begin
                    s0.shift = i_data;
                    s0.phase = i_data[0] ? PH_W1LOW : PH_W0LOW;
                end
                default: begin
                    s0.shift = '0;
                    s0.phase = PH_RDLOW;
                end
            endcase
            t0 = phase_ticks(s0.phase, i_cfg);
        end

        busy = (s0.phase != PH_IDLE);
        if (s0.phase == PH_RSAMP) begin
            pres = ~i_line;
        end
        if (s0.phase == PH_RDSAMP) begin
            s0.shift = {i_line, s0.shift[BYTE_W-1:1]};
        end
        tdec = (t0 != '0) ? t0 - 10'd1 : '0;

        // zero-length phases are skipped; at most three hops reach a timed one
        s1 = successor(s0);
        s2 = (s1.phase != PH_IDLE && phase_ticks(s1.phase, i_cfg) == '0) ?
             successor(s1) : s1;
        s3 = (s2.phase != PH_IDLE && phase_ticks(s2.phase, i_cfg) == '0) ?
             successor(s2) : s2;

        done = 1'b0;
        if (busy && tdec == '0) begin
            n_seq       = s3;
            n_time_left = phase_ticks(s3.phase, i_cfg);
            done        = (s3.phase == PH_IDLE);
        end else begin
            n_seq       = s0;
            n_time_left = tdec;
        end

        o_res.drive      = busy ? phase_drive(s0.phase) : DRV_RELEASE;
        o_res.busy       = busy;
        o_res.done       = done;
        o_res.presence   = pres;
        o_res.read_value = n_seq.rd_val;
        o_res.rejected   = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_read      <= '0;
        end else if (i_step) begin
            r_phase     <= n_seq.phase;
            r_time_left <= n_time_left;
            r_bit_idx   <= n_seq.bit_idx;
            r_shift     <= n_seq.shift;
            r_presence  <= pres;
            r_read      <= n_seq.rd_val;
        end
    end

    a_timer_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_time_left == '0))
        else $error("timer and phase disagree");

    a_presence_at_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_presence) |-> $past(r_phase) == PH_RSAMP)
        else $error("presence changed outside its sample tick");

    a_read_at_slot_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_read) |->
            ($past(r_phase) == PH_RDTAIL || $past(r_phase) == PH_RDSAMP))
        else $error("read byte changed outside the last read slot");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 1-Wire bus master unit.
// ----------------------------------------------------------------------------
// One request is one microsecond tick. A behavioral model of the sequencer
// runs on every accepted request, and its results are queued. Each accepted
// result is checked field by field against the oldest queued one. The run
// starts at the default timing, moves to floor values, then to several random
// timing sets. Both stream sides idle at random, the receiver once holds off
// for a long stretch, and the sender drains between timing sets.
// ----------------------------------------------------------------------------
module testbench;
    import owbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_ITEMS  = 700;
    localparam int LONG_HOLD   = 400;
    localparam int LINE_LOW    = 0;
    localparam int LINE_HIGH   = 1;
    localparam int LINE_RAND   = 2;

    // one request, packed the way the slave stream carries it
    typedef struct packed {
        logic                line;
        logic [BYTE_W-1:0]   data;
        t_cmd                cmd;
    } tick_req_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic              cfg_we    = 1'b0;
    logic [2:0]        cfg_idx   = '0;
    logic [US_W-1:0]   cfg_data  = '0;

    one_wire_bus_master_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model of the sequencer
    logic [US_W-1:0]   cfg_us [8] = '{10'd480, 10'd60, 10'd240, 10'd14,
                                      10'd46, 10'd2, 10'd60, 10'd2};
    t_phase            seq_phase = PH_IDLE;
    int                tick_cnt  = 0;
    logic [BIT_W-1:0]  bit_pos   = '0;
    logic [BYTE_W-1:0] shreg     = '0;
    logic              pres_seen = 1'b0;
    logic [BYTE_W-1:0] last_rd   = '0;

    tick_req_t  pending_reqs [$];
    t_res       tick_expect [$];
    tick_req_t  cur_req;
    int         issued_cnt   = 0;
    int         accepted_cnt = 0;
    int         checked_cnt  = 0;
    int         err_cnt      = 0;
    int         rej_cnt      = 0;
    int         op_cnt [4]   = '{0, 0, 0, 0};
    int         tx_gap       = 0;
    int         rx_wait      = 0;
    int         hold_asked   = 0;
    int         hold_given   = 0;
    int         cycle_cnt    = 0;
    bit         tx_burst     = 1'b0;
    bit         rx_burst     = 1'b0;

    function automatic int span_of(t_phase p);
        int lo;
        int slot;
        int n;
        lo   = (cfg_us[REG_W1_LOW] == 0) ? 1 : int'(cfg_us[REG_W1_LOW]);
        slot = (cfg_us[REG_W_SLOT] < 2) ? 2 : int'(cfg_us[REG_W_SLOT]);
        case (p)
            PH_RLOW:   n = (cfg_us[REG_RESET_LOW] == 0) ? 1 : int'(cfg_us[REG_RESET_LOW]);
            PH_RWAIT:  n = (cfg_us[REG_PRES_WAIT] == 0) ? 1 : int'(cfg_us[REG_PRES_WAIT]);
            PH_RSAMP:  n = 1;
            PH_RTAIL:  n = int'(cfg_us[REG_PRES_TAIL]);
            PH_W1LOW:  n = lo;
            PH_W1HIGH: n = (slot > lo) ? slot - lo : 0;
            PH_W0LOW:  n = slot;
            PH_RECOV:  n = int'(cfg_us[REG_RECOVERY]);
            PH_RDLOW:  n = 1;
            PH_RDWAIT: n = (cfg_us[REG_READ_SAMP] == 0) ? 1 : int'(cfg_us[REG_READ_SAMP]);
            PH_RDSAMP: n = 1;
            PH_RDTAIL: n = int'(cfg_us[REG_READ_TAIL]);
            default:   n = 0;
        endcase
        return n;
    endfunction

    // following phase; moves to the next bit at the end of a slot
    function automatic t_phase advance(t_phase p);
        t_phase n;
        n = PH_IDLE;
        case (p)
            PH_RLOW:             n = PH_RWAIT;
            PH_RWAIT:            n = PH_RSAMP;
            PH_RSAMP:            n = PH_RTAIL;
            PH_W1LOW:            n = PH_W1HIGH;
            PH_W1HIGH, PH_W0LOW: n = PH_RECOV;
            PH_RECOV: begin
                if (bit_pos != LAST_BIT) begin
                    bit_pos = bit_pos + 3'd1;
                    shreg   = shreg >> 1;
                    if (shreg[0]) n = PH_W1LOW;
                    else n = PH_W0LOW;
                end
            end
            PH_RDLOW:            n = PH_RDWAIT;
            PH_RDWAIT:           n = PH_RDSAMP;
            PH_RDSAMP:           n = PH_RDTAIL;
            PH_RDTAIL: begin
                if (bit_pos == LAST_BIT) begin
                    last_rd = shreg;
                end else begin
                    bit_pos = bit_pos + 3'd1;
                    n = PH_RDLOW;
                end
            end
            default:             n = PH_IDLE;
        endcase
        return n;
    endfunction

    // zero-length phases are passed over
    function automatic void enter_phase(t_phase p);
        seq_phase = p;
        tick_cnt  = span_of(p);
        while (seq_phase != PH_IDLE && tick_cnt == 0) begin
            seq_phase = advance(seq_phase);
            tick_cnt  = span_of(seq_phase);
        end
    endfunction

    function automatic t_res bus_tick(tick_req_t r);
        t_res o;
        o = '0;
        o.drive = DRV_RELEASE;
        if (seq_phase != PH_IDLE) begin
            if (r.cmd != CMD_NONE) begin
                o.rejected = 1'b1;
                rej_cnt++;
            end
        end else if (r.cmd != CMD_NONE) begin
            bit_pos = '0;
            op_cnt[r.cmd]++;
            case (r.cmd)
                CMD_RESET: begin
                    shreg = '0;
                    enter_phase(PH_RLOW);
                end
                CMD_WRITE: begin
                    shreg = r.data;
                    if (r.data[0]) enter_phase(PH_W1LOW);
                    else enter_phase(PH_W0LOW);
                end
                default: begin
                    shreg = '0;
                    enter_phase(PH_RDLOW);
                end
            endcase
        end
        if (seq_phase != PH_IDLE) begin
            o.busy = 1'b1;
            case (seq_phase)
                PH_RLOW, PH_W1LOW, PH_W0LOW, PH_RDLOW: o.drive = DRV_LOW;
                PH_W1HIGH:                             o.drive = DRV_HIGH;
                default:                               o.drive = DRV_RELEASE;
            endcase
            if (seq_phase == PH_RSAMP) pres_seen = ~r.line;
            else if (seq_phase == PH_RDSAMP) shreg = {r.line, shreg[BYTE_W-1:1]};
            if (tick_cnt > 0) tick_cnt--;
            if (tick_cnt == 0) begin
                enter_phase(advance(seq_phase));
                if (seq_phase == PH_IDLE) o.done = 1'b1;
            end
        end
        o.presence   = pres_seen;
        o.read_value = last_rd;
        return o;
    endfunction

    // length in ticks of an operation under the current timing
    function automatic int op_ticks(t_cmd c, logic [BYTE_W-1:0] d);
        int n;
        n = 0;
        case (c)
            CMD_RESET: n = span_of(PH_RLOW) + span_of(PH_RWAIT) + 1 + span_of(PH_RTAIL);
            CMD_WRITE: begin
                for (int i = 0; i < BYTE_W; i++) begin
                    if (d[i]) n += span_of(PH_W1LOW) + span_of(PH_W1HIGH);
                    else n += span_of(PH_W0LOW);
                    n += span_of(PH_RECOV);
                end
            end
            CMD_READ:  n = BYTE_W * (2 + span_of(PH_RDWAIT) + span_of(PH_RDTAIL));
            default:   n = 1;
        endcase
        return n;
    endfunction

    function automatic void queue_req(t_cmd c, logic [BYTE_W-1:0] d, logic ln);
        tick_req_t r;
        r.cmd  = c;
        r.data = d;
        r.line = ln;
        pending_reqs.push_back(r);
        issued_cnt++;
    endfunction

    function automatic void add_idle(int n);
        for (int k = 0; k < n; k++) queue_req(CMD_NONE, BYTE_W'($urandom), 1'($urandom));
    endfunction

    // a command and the ticks it runs for; noise_pct of the busy ticks
    // carry a command that must be turned away
    function automatic int add_op(t_cmd c, logic [BYTE_W-1:0] d, int line_mode, int noise_pct);
        int n;
        t_cmd k_cmd;
        logic ln;
        n = op_ticks(c, d);
        for (int k = 0; k < n; k++) begin
            if (k == 0) k_cmd = c;
            else if ($urandom_range(0, 99) < noise_pct) k_cmd = t_cmd'($urandom_range(1, 3));
            else k_cmd = CMD_NONE;
            if (line_mode == LINE_LOW) ln = 1'b0;
            else if (line_mode == LINE_HIGH) ln = 1'b1;
            else ln = 1'($urandom);
            queue_req(k_cmd, (k == 0) ? d : BYTE_W'($urandom), ln);
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [US_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        cfg_us[idx] = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (accepted_cnt != issued_cnt || tick_expect.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // slave side: requests from the pending queue with random gaps
    always @(posedge clk) begin : driver
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                tick_expect.push_back(bus_tick(cur_req));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_tdata  <= {5'b0, cur_req};
                    s_tvalid <= 1'b1;
                    tx_gap = tx_burst ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // master side: random back-pressure plus one long hold-off on request
    always @(posedge clk) begin : receiver
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_asked != hold_given) begin
                hold_given = hold_asked;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!rx_burst) rx_wait = pick_gap();
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (tick_expect.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                err_cnt++;
            end else begin
                want = tick_expect.pop_front();
                check_field("line_drive", want.drive, m_tdata[1:0]);
                check_field("busy_res", want.busy, m_tdata[2]);
                check_field("done_res", want.done, m_tdata[3]);
                check_field("presence_found", want.presence, m_tdata[4]);
                check_field("read_value", want.read_value, m_tdata[12:5]);
                check_field("rejected", want.rejected, m_tdata[13]);
                checked_cnt++;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        logic [US_W-1:0] v [8];
        logic [BYTE_W-1:0] d;
        t_cmd c;
        int n_rand;
        int ph;
        int ph_items;
        int r;
        int g;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing as it comes out of reset
        add_idle(2);
        void'(add_op(CMD_WRITE, 8'hA5, LINE_RAND, 3));
        drain();

        // floor values: below-minimum registers, zero tails and recovery
        write_reg(REG_RESET_LOW, 10'd0);
        write_reg(REG_PRES_WAIT, 10'd0);
        write_reg(REG_PRES_TAIL, 10'd0);
        write_reg(REG_READ_SAMP, 10'd0);
        write_reg(REG_READ_TAIL, 10'd0);
        write_reg(REG_W1_LOW, 10'd0);
        write_reg(REG_W_SLOT, 10'd1);
        write_reg(REG_RECOVERY, 10'd0);
        queue_req(CMD_NONE, 8'hFF, 1'b1);
        void'(add_op(CMD_RESET, 8'h00, LINE_LOW, 0));
        // absent device; every busy tick, done tick too, carries a command
        void'(add_op(CMD_RESET, 8'hFF, LINE_HIGH, 100));
        void'(add_op(CMD_WRITE, 8'hFF, LINE_RAND, 0));
        void'(add_op(CMD_READ, 8'h00, LINE_RAND, 10));
        drain();

        n_rand = 0;
        ph = 0;
        while (n_rand < RAND_ITEMS) begin
            for (int k = 0; k < 8; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) v[k] = '0;
                else if (r < 80) v[k] = US_W'($urandom_range(1, 8));
                else v[k] = US_W'($urandom_range(9, 40));
            end
            // one-slot low time at or past the slot length
            if ($urandom_range(0, 3) == 0) begin
                v[REG_W_SLOT] = US_W'($urandom_range(0, int'(v[REG_W1_LOW])));
            end
            for (int k = 0; k < 8; k++) write_reg(t_reg_idx'(k), v[k]);
            tx_burst = (ph % 4 == 1);
            rx_burst = (ph % 4 == 2);
            ph_items = 0;
            while (ph_items < 160) begin
                r = $urandom_range(0, 99);
                if (r < 30) c = CMD_RESET;
                else if (r < 65) c = CMD_WRITE;
                else c = CMD_READ;
                r = $urandom_range(0, 9);
                if (r == 0) d = 8'h00;
                else if (r == 1) d = 8'hFF;
                else d = BYTE_W'($urandom);
                ph_items += add_op(c, d, LINE_RAND, 5);
                g = $urandom_range(0, 3);
                add_idle(g);
                ph_items += g;
            end
            // receiver stalls while the sender keeps offering
            if (ph == 1) hold_asked++;
            drain();
            n_rand += ph_items;
            ph++;
        end

        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (10) @(posedge clk);

        $display("checked %0d ticks: %0d resets, %0d writes, %0d reads, %0d rejected commands",
                 checked_cnt, op_cnt[CMD_RESET], op_cnt[CMD_WRITE], op_cnt[CMD_READ], rej_cnt);
        $display("timing: defaults, floor values and %0d random sets", ph);
        if (err_cnt == 0 && tick_expect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
